### rtl/core/assert_macros.svh
// assertion macros used by the port-level checker of the lamp controller
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion clocked on rising edge, off while reset is low
`define ASSERT_CLK(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lamp controller check failed");

// same, for a plain implication from a condition to a consequence
`define ASSERT_IMPLY(label, clk, rstn, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
    else $error("lamp controller implication failed");

`endif

### rtl/core/rlmf_pkg.sv
// types, constants and curve tables of the rgb lamp mode and fade controller
// no dependencies; used by every module of the block
package rlmf_pkg;

  // event codes
  localparam logic [1:0] OpTick    = 2'd0;
  localparam logic [1:0] OpPin     = 2'd1;
  localparam logic [1:0] OpTimeout = 2'd2;

  // lamp modes
  localparam logic [3:0] ModeOff      = 4'd0;
  localparam logic [3:0] ModeWarm     = 4'd1;
  localparam logic [3:0] ModeSlowRgb  = 4'd2;
  localparam logic [3:0] ModeSun      = 4'd3;
  localparam logic [3:0] ModeRed      = 4'd4;
  localparam logic [3:0] ModeGreen    = 4'd5;
  localparam logic [3:0] ModeBlue     = 4'd6;
  localparam logic [3:0] ModeYellow   = 4'd7;
  localparam logic [3:0] ModeMagenta  = 4'd8;
  localparam logic [3:0] ModeCyan     = 4'd9;
  localparam logic [3:0] ModeFastRgb  = 4'd10;
  localparam logic [3:0] ModeSlowRgb2 = 4'd11;
  localparam logic [3:0] ModeFastRgb2 = 4'd12;
  localparam logic [3:0] NumModes     = 4'd13;

  // pin bits
  localparam logic [3:0] PinWarm  = 4'b0001;
  localparam logic [3:0] PinRed   = 4'b0010;
  localparam logic [3:0] PinGreen = 4'b0100;
  localparam logic [3:0] PinBlue  = 4'b1000;

  // timebase wraps
  localparam logic [3:0] TickWrap = 4'd10;
  localparam logic [7:0] StepWrap = 8'd252;
  localparam logic [7:0] MidWrap  = 8'd255;
  localparam logic [7:0] SlowWrap = 8'd221;

  // register map
  localparam logic [1:0] AddrEnergyFull  = 2'd0;
  localparam logic [19:0] EnergyFullRst  = 20'd65535;

  localparam int ShortLen = 42;
  localparam int LongLen  = 84;

  localparam logic [7:0] ShortCurve [ShortLen] = '{
    8'd254, 8'd223, 8'd196, 8'd171, 8'd150, 8'd131, 8'd115, 8'd101, 8'd88, 8'd77,
    8'd67, 8'd59, 8'd52, 8'd45, 8'd39, 8'd34, 8'd30, 8'd26, 8'd23, 8'd20,
    8'd17, 8'd15, 8'd13, 8'd11, 8'd10, 8'd8, 8'd7, 8'd6, 8'd5, 8'd5,
    8'd4, 8'd3, 8'd3, 8'd2, 8'd2, 8'd2, 8'd1, 8'd1, 8'd1, 8'd0,
    8'd0, 8'd0
  };

  localparam logic [7:0] LongCurve [LongLen] = '{
    8'd254, 8'd239, 8'd223, 8'd209, 8'd196, 8'd183, 8'd171, 8'd160, 8'd150, 8'd140,
    8'd131, 8'd123, 8'd115, 8'd108, 8'd101, 8'd94, 8'd88, 8'd82, 8'd77, 8'd72,
    8'd67, 8'd63, 8'd59, 8'd55, 8'd52, 8'd48, 8'd45, 8'd42, 8'd39, 8'd37,
    8'd34, 8'd32, 8'd30, 8'd28, 8'd26, 8'd24, 8'd23, 8'd21, 8'd20, 8'd19,
    8'd17, 8'd16, 8'd15, 8'd14, 8'd13, 8'd12, 8'd11, 8'd11, 8'd10, 8'd9,
    8'd8, 8'd8, 8'd7, 8'd7, 8'd6, 8'd6, 8'd5, 8'd5, 8'd5, 8'd4,
    8'd4, 8'd4, 8'd3, 8'd3, 8'd3, 8'd3, 8'd2, 8'd2, 8'd2, 8'd2,
    8'd2, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0
  };

  typedef struct packed {
    logic [1:0] opcode;
    logic       button_pressed;
    logic       charger_present;
  } in_word_t;

  typedef struct packed {
    logic [3:0] mode_now;
    logic       warm_white_on;
    logic       pwm_active;
    logic       red_drive;
    logic       green_drive;
    logic       blue_drive;
    logic [7:0] duty_red;
    logic [7:0] duty_green;
    logic [7:0] duty_blue;
    logic       charge_led;
    logic       low_energy_flash;
  } out_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } duty_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [7:0]  fine_step;
    logic [7:0]  coarse_step;
    logic [3:0]  tick_div;
    logic [7:0]  mid_div;
    logic [7:0]  slow_div;
    logic [20:0] budget;     // two's complement, never below -1
    logic        debouncing;
    logic        charging;
    duty_t       duty;
  } state_t;

  function automatic logic [3:0] mode_cost(input logic [3:0] mode);
    logic [3:0] cost;
    unique case (mode)
      ModeWarm:     cost = 4'd2;
      ModeSlowRgb:  cost = 4'd3;
      ModeSun:      cost = 4'd9;
      ModeRed:      cost = 4'd3;
      ModeGreen:    cost = 4'd2;
      ModeBlue:     cost = 4'd2;
      ModeYellow:   cost = 4'd5;
      ModeMagenta:  cost = 4'd5;
      ModeCyan:     cost = 4'd4;
      ModeFastRgb:  cost = 4'd3;
      ModeSlowRgb2: cost = 4'd1;
      ModeFastRgb2: cost = 4'd1;
      default:      cost = 4'd0;
    endcase
    return cost;
  endfunction

  function automatic logic [3:0] mode_pins(input logic [3:0] mode);
    logic [3:0] pins;
    unique case (mode)
      ModeWarm:    pins = PinWarm;
      ModeSun:     pins = PinWarm | PinRed | PinGreen | PinBlue;
      ModeRed:     pins = PinRed;
      ModeGreen:   pins = PinGreen;
      ModeBlue:    pins = PinBlue;
      ModeYellow:  pins = PinRed | PinGreen;
      ModeMagenta: pins = PinRed | PinBlue;
      ModeCyan:    pins = PinGreen | PinBlue;
      default:     pins = 4'b0000;
    endcase
    return pins;
  endfunction

  function automatic logic is_pwm_mode(input logic [3:0] mode);
    return (mode == ModeSlowRgb) || (mode == ModeFastRgb) ||
           (mode == ModeSlowRgb2) || (mode == ModeFastRgb2);
  endfunction

endpackage

### rtl/core/rlmf_fade.sv
// fade curve lookup: next pwm duties from the mode and the animation counters
// depends on rlmf_pkg
module rlmf_fade (
  input  logic [3:0]      mode_i,
  input  logic [7:0]      fine_step_i,
  input  logic [7:0]      coarse_step_i,
  input  rlmf_pkg::duty_t duty_i,
  output rlmf_pkg::duty_t duty_o
);

  logic [7:0] pos;
  logic [2:0] short_seg;
  logic [5:0] short_off;
  logic [1:0] long_seg;
  logic [6:0] long_off;
  logic [7:0] short_fwd, short_rev, long_fwd, long_rev;

  // fast modes run on the fine counter, slow ones on the coarse counter
  assign pos = (mode_i == rlmf_pkg::ModeFastRgb || mode_i == rlmf_pkg::ModeFastRgb2) ?
               fine_step_i : coarse_step_i;

  always_comb begin
    if (pos < 8'(rlmf_pkg::ShortLen)) begin
      short_seg = 3'd0;
      short_off = 6'(pos);
    end else if (pos < 8'(2 * rlmf_pkg::ShortLen)) begin
      short_seg = 3'd1;
      short_off = 6'(pos - 8'(rlmf_pkg::ShortLen));
    end else if (pos < 8'(3 * rlmf_pkg::ShortLen)) begin
      short_seg = 3'd2;
      short_off = 6'(pos - 8'(2 * rlmf_pkg::ShortLen));
    end else if (pos < 8'(4 * rlmf_pkg::ShortLen)) begin
      short_seg = 3'd3;
      short_off = 6'(pos - 8'(3 * rlmf_pkg::ShortLen));
    end else if (pos < 8'(5 * rlmf_pkg::ShortLen)) begin
      short_seg = 3'd4;
      short_off = 6'(pos - 8'(4 * rlmf_pkg::ShortLen));
    end else if (pos < 8'(6 * rlmf_pkg::ShortLen)) begin
      short_seg = 3'd5;
      short_off = 6'(pos - 8'(5 * rlmf_pkg::ShortLen));
    end else begin
      short_seg = 3'd6;
      short_off = 6'd0;
    end
  end

  always_comb begin
    if (pos < 8'(rlmf_pkg::LongLen)) begin
      long_seg = 2'd0;
      long_off = 7'(pos);
    end else if (pos < 8'(2 * rlmf_pkg::LongLen)) begin
      long_seg = 2'd1;
      long_off = 7'(pos - 8'(rlmf_pkg::LongLen));
    end else if (pos < 8'(3 * rlmf_pkg::LongLen)) begin
      long_seg = 2'd2;
      long_off = 7'(pos - 8'(2 * rlmf_pkg::LongLen));
    end else begin
      long_seg = 2'd3;
      long_off = 7'd0;
    end
  end

  assign short_fwd = rlmf_pkg::ShortCurve[short_off];
  assign short_rev = rlmf_pkg::ShortCurve[6'(rlmf_pkg::ShortLen - 1) - short_off];
  assign long_fwd  = rlmf_pkg::LongCurve[long_off];
  assign long_rev  = rlmf_pkg::LongCurve[7'(rlmf_pkg::LongLen - 1) - long_off];

  always_comb begin
    duty_o = duty_i;
    if (mode_i == rlmf_pkg::ModeSlowRgb || mode_i == rlmf_pkg::ModeFastRgb) begin
      case (short_seg)
        3'd0:    duty_o.green = short_rev;
        3'd1:    duty_o.red   = short_fwd;
        3'd2:    duty_o.blue  = short_rev;
        3'd3:    duty_o.green = short_fwd;
        3'd4:    duty_o.red   = short_rev;
        3'd5:    duty_o.blue  = short_fwd;
        default: ;
      endcase
    end else if (mode_i == rlmf_pkg::ModeSlowRgb2 || mode_i == rlmf_pkg::ModeFastRgb2) begin
      case (long_seg)
        2'd0: begin
          duty_o.red   = long_fwd;
          duty_o.green = long_rev;
        end
        2'd1: begin
          duty_o.green = long_fwd;
          duty_o.blue  = long_rev;
        end
        2'd2: begin
          duty_o.red  = long_rev;
          duty_o.blue = long_fwd;
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/rlmf_step.sv
// single-pass step logic: event handling, timebase, fade, energy budget, pins
// depends on rlmf_pkg and rlmf_fade
module rlmf_step (
  input  rlmf_pkg::state_t    state_i,
  input  rlmf_pkg::in_word_t  word_i,
  input  logic [19:0]         energy_full_i,
  output rlmf_pkg::state_t    state_o,
  output rlmf_pkg::out_word_t word_o
);

  rlmf_pkg::state_t evt;
  rlmf_pkg::duty_t  duty_fade;
  logic             fire;
  logic             flash;
  logic             pwm;
  logic [3:0]       pins;
  logic [21:0]      diff;

  // event handling and timebase
  always_comb begin
    evt  = state_i;
    fire = 1'b0;
    if (evt.mode >= rlmf_pkg::NumModes) begin
      evt.mode = rlmf_pkg::ModeOff;
    end
    case (word_i.opcode)
      rlmf_pkg::OpTick: begin
        // timer is stopped while off
        if (evt.mode != rlmf_pkg::ModeOff) begin
          evt.tick_div = evt.tick_div + 4'd1;
          if (evt.tick_div == rlmf_pkg::TickWrap) begin
            evt.tick_div  = 4'd0;
            evt.fine_step = evt.fine_step + 8'd1;
            if (evt.fine_step == rlmf_pkg::StepWrap) begin
              evt.fine_step   = 8'd0;
              evt.coarse_step = evt.coarse_step + 8'd1;
              if (evt.coarse_step == rlmf_pkg::StepWrap) begin
                evt.coarse_step = 8'd0;
              end
            end
            evt.mid_div = evt.mid_div + 8'd1;
            if (evt.mid_div == rlmf_pkg::MidWrap) begin
              evt.mid_div  = 8'd0;
              evt.slow_div = evt.slow_div + 8'd1;
              if (evt.slow_div == rlmf_pkg::SlowWrap) begin
                evt.slow_div = 8'd0;
                fire         = 1'b1;
              end
            end
          end
        end
      end
      rlmf_pkg::OpPin: begin
        if (word_i.button_pressed && !evt.debouncing) begin
          evt.mode = (evt.mode == rlmf_pkg::ModeFastRgb2) ? rlmf_pkg::ModeOff :
                     evt.mode + 4'd1;
        end
        evt.charging = word_i.charger_present;
        if (word_i.charger_present) begin
          evt.budget = {1'b0, energy_full_i};
        end
        evt.debouncing = 1'b1;
      end
      rlmf_pkg::OpTimeout: begin
        if (evt.debouncing) begin
          evt.debouncing = 1'b0;
          // long press forces the lamp off
          if (word_i.button_pressed) begin
            evt.mode = rlmf_pkg::ModeOff;
          end
        end
      end
      default: ;
    endcase
  end

  rlmf_fade u_fade (
    .mode_i        (evt.mode),
    .fine_step_i   (evt.fine_step),
    .coarse_step_i (evt.coarse_step),
    .duty_i        (evt.duty),
    .duty_o        (duty_fade)
  );

  // energy budget and outputs
  always_comb begin
    state_o      = evt;
    state_o.duty = duty_fade;
    flash        = 1'b0;
    pins         = rlmf_pkg::mode_pins(evt.mode);
    diff         = {evt.budget[20], evt.budget} -
                   (fire ? {18'd0, rlmf_pkg::mode_cost(evt.mode)} : 22'd0);
    if (evt.mode != rlmf_pkg::ModeOff) begin
      if (diff[21]) begin
        state_o.budget = '1;
        state_o.mode   = rlmf_pkg::ModeOff;
        pins           = rlmf_pkg::PinRed;
        flash          = 1'b1;
      end else begin
        state_o.budget = diff[20:0];
      end
    end
    pwm = !flash && rlmf_pkg::is_pwm_mode(state_o.mode);

    word_o.mode_now         = state_o.mode;
    word_o.warm_white_on    = |(pins & rlmf_pkg::PinWarm);
    word_o.pwm_active       = pwm;
    word_o.red_drive        = pwm ? (duty_fade.red != 8'd0) : |(pins & rlmf_pkg::PinRed);
    word_o.green_drive      = pwm ? (duty_fade.green != 8'd0) : |(pins & rlmf_pkg::PinGreen);
    word_o.blue_drive       = pwm ? (duty_fade.blue != 8'd0) : |(pins & rlmf_pkg::PinBlue);
    word_o.duty_red         = duty_fade.red;
    word_o.duty_green       = duty_fade.green;
    word_o.duty_blue        = duty_fade.blue;
    word_o.charge_led       = evt.charging;
    word_o.low_energy_flash = flash;
  end

endmodule

### rtl/core/rlmf_cfg.sv
// apb-style configuration register: energy_full
// depends on rlmf_pkg
module rlmf_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [19:0] energy_full_o
);

  logic [19:0] energy_full_q, energy_full_d;
  logic        wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready && (paddr == rlmf_pkg::AddrEnergyFull);

  assign energy_full_d = wr_hit ? pwdata[19:0] : energy_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_full_q <= rlmf_pkg::EnergyFullRst;
    end else begin
      energy_full_q <= energy_full_d;
    end
  end

  assign prdata        = (paddr == rlmf_pkg::AddrEnergyFull) ? {12'd0, energy_full_q} : 32'd0;
  assign energy_full_o = energy_full_q;

endmodule

### rtl/core/rgb_lamp_mode_fade_controller.sv
// top level of the rgb plus warm-white lamp mode and fade controller
// depends on rlmf_pkg, rlmf_step, rlmf_cfg
//
//   channel   direction  handshake                      word
//   input     in         in_valid_i / in_ready_o        rlmf_pkg::in_word_t
//   result    out        out_valid_o / out_ready_i      rlmf_pkg::out_word_t
//   config    in/out     psel/penable/pwrite, pready    energy_full at byte address 0
//
// one word per cycle sustained while results are taken; an accepted word sits in
// the input register and passes the step logic (event, timebase, fade lookup,
// budget) into the result register, raising out_valid_o, once that slot is free
// reset clears all lamp state (budget 0, mode off, duties 0), energy_full = 65535
// a stalled result holds; the input register still takes one more word and
// then in_ready_o drops until the result is taken
module rgb_lamp_mode_fade_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input words
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rlmf_pkg::in_word_t  in_word_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rlmf_pkg::out_word_t out_word_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic                in_valid_q, in_valid_d;
  rlmf_pkg::in_word_t  in_word_q;
  logic                out_valid_q, out_valid_d;
  rlmf_pkg::out_word_t out_word_q, out_word_d;
  rlmf_pkg::state_t    state_q, state_d;
  rlmf_pkg::state_t    state_next;
  logic [19:0]         energy_full;
  logic                in_fire;
  logic                advance;

  // --- configuration register ---
  rlmf_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .energy_full_o (energy_full)
  );

  // --- handshake ---
  // the registered word moves into the result register whenever that slot
  // is empty or being emptied this cycle
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // --- step logic: all work for one word between the two registers ---
  rlmf_step u_step (
    .state_i       (state_q),
    .word_i        (in_word_q),
    .energy_full_i (energy_full),
    .state_o       (state_next),
    .word_o        (out_word_d)
  );

  // lamp state only moves when its word is handed to the result register
  assign state_d = advance ? state_next : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_word_q <= in_word_i;
    end
    if (advance) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

### rtl/core/rlmf_checker.sv
// port-level checks on the lamp controller result channel, bound to the top level
// depends on rlmf_pkg and assert_macros.svh
`include "assert_macros.svh"

module rlmf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input rlmf_pkg::out_word_t out_word_o
);

  // a stalled result stays put
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))

  // underflow flash shows only red with the lamp off
  `ASSERT_IMPLY(a_flash_red_only, clk_i, rst_ni,
    out_valid_o && out_word_o.low_energy_flash,
    out_word_o.mode_now == rlmf_pkg::ModeOff && out_word_o.red_drive &&
    !out_word_o.green_drive && !out_word_o.blue_drive &&
    !out_word_o.warm_white_on && !out_word_o.pwm_active)

  // pwm only in the four fade modes
  `ASSERT_IMPLY(a_pwm_fade_mode, clk_i, rst_ni,
    out_valid_o && out_word_o.pwm_active,
    out_word_o.mode_now == rlmf_pkg::ModeSlowRgb ||
    out_word_o.mode_now == rlmf_pkg::ModeFastRgb ||
    out_word_o.mode_now == rlmf_pkg::ModeSlowRgb2 ||
    out_word_o.mode_now == rlmf_pkg::ModeFastRgb2)

  // lamp off without flash drives no pin
  `ASSERT_IMPLY(a_off_dark, clk_i, rst_ni,
    out_valid_o && out_word_o.mode_now == rlmf_pkg::ModeOff &&
    !out_word_o.low_energy_flash,
    !out_word_o.red_drive && !out_word_o.green_drive && !out_word_o.blue_drive &&
    !out_word_o.warm_white_on && !out_word_o.pwm_active)

endmodule

bind rgb_lamp_mode_fade_controller rlmf_checker u_rlmf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

### bench/rlmf_lamp_checker.sv
`timescale 1ns / 100ps
// scoreboard for the rgb lamp mode and fade controller: watches both word channels
// and the config port, predicts every result word and compares it field by field
// depends on rlmf_pkg for the word types, event codes, mode and register names
module rlmf_lamp_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  rlmf_pkg::in_word_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  rlmf_pkg::out_word_t out_word_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [1:0]          paddr_i,
  input  logic [31:0]         pwdata_i,
  input  logic                pready_i,
  output int                  mismatch_count_o,
  output int                  pending_words_o
);

  localparam int FadeShortLen = 42;
  localparam int FadeLongLen  = 84;

  localparam logic [7:0] FadeShort [FadeShortLen] = '{
    8'd254, 8'd223, 8'd196, 8'd171, 8'd150, 8'd131, 8'd115, 8'd101, 8'd88, 8'd77,
    8'd67, 8'd59, 8'd52, 8'd45, 8'd39, 8'd34, 8'd30, 8'd26, 8'd23, 8'd20,
    8'd17, 8'd15, 8'd13, 8'd11, 8'd10, 8'd8, 8'd7, 8'd6, 8'd5, 8'd5,
    8'd4, 8'd3, 8'd3, 8'd2, 8'd2, 8'd2, 8'd1, 8'd1, 8'd1, 8'd0,
    8'd0, 8'd0
  };

  localparam logic [7:0] FadeLong [FadeLongLen] = '{
    8'd254, 8'd239, 8'd223, 8'd209, 8'd196, 8'd183, 8'd171, 8'd160, 8'd150, 8'd140,
    8'd131, 8'd123, 8'd115, 8'd108, 8'd101, 8'd94, 8'd88, 8'd82, 8'd77, 8'd72,
    8'd67, 8'd63, 8'd59, 8'd55, 8'd52, 8'd48, 8'd45, 8'd42, 8'd39, 8'd37,
    8'd34, 8'd32, 8'd30, 8'd28, 8'd26, 8'd24, 8'd23, 8'd21, 8'd20, 8'd19,
    8'd17, 8'd16, 8'd15, 8'd14, 8'd13, 8'd12, 8'd11, 8'd11, 8'd10, 8'd9,
    8'd8, 8'd8, 8'd7, 8'd7, 8'd6, 8'd6, 8'd5, 8'd5, 8'd5, 8'd4,
    8'd4, 8'd4, 8'd3, 8'd3, 8'd3, 8'd3, 8'd2, 8'd2, 8'd2, 8'd2,
    8'd2, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0
  };

  // energy spent per budget tick, indexed by mode
  localparam logic [3:0] CostOfMode [13] = '{
    4'd0, 4'd2, 4'd3, 4'd9, 4'd3, 4'd2, 4'd2, 4'd5, 4'd5, 4'd4, 4'd3, 4'd1, 4'd1
  };

  localparam logic [3:0] PinsOfMode [13] = '{
    4'b0000, rlmf_pkg::PinWarm, 4'b0000,
    rlmf_pkg::PinWarm | rlmf_pkg::PinRed | rlmf_pkg::PinGreen | rlmf_pkg::PinBlue,
    rlmf_pkg::PinRed, rlmf_pkg::PinGreen, rlmf_pkg::PinBlue,
    rlmf_pkg::PinRed | rlmf_pkg::PinGreen, rlmf_pkg::PinRed | rlmf_pkg::PinBlue,
    rlmf_pkg::PinGreen | rlmf_pkg::PinBlue, 4'b0000, 4'b0000, 4'b0000
  };

  logic [3:0]          mode_q;
  logic [7:0]          fine_q, coarse_q, mid_q, slow_q;
  logic [3:0]          tick_q, pins_q;
  logic [7:0]          duty_r_q, duty_g_q, duty_b_q;
  logic signed [20:0]  budget_q;
  logic                debounce_q, charging_q;
  logic [19:0]         full_level_q;
  rlmf_pkg::out_word_t lamp_words_q[$];
  int                  mismatches = 0;

  assign mismatch_count_o = mismatches;

  // advances the lamp state by one event and returns the word it should show
  function automatic rlmf_pkg::out_word_t lamp_step(input rlmf_pkg::in_word_t w);
    rlmf_pkg::out_word_t o;
    logic                fire, flash, pwm;
    int                  s;
    fire  = 1'b0;
    flash = 1'b0;
    s     = -1;
    case (w.opcode)
      rlmf_pkg::OpTick: begin
        // timer is stopped while off
        if (mode_q != rlmf_pkg::ModeOff) begin
          tick_q = tick_q + 4'd1;
          if (tick_q == rlmf_pkg::TickWrap) begin
            tick_q = 4'd0;
            fine_q = fine_q + 8'd1;
            if (fine_q == rlmf_pkg::StepWrap) begin
              fine_q   = 8'd0;
              coarse_q = coarse_q + 8'd1;
              if (coarse_q == rlmf_pkg::StepWrap) coarse_q = 8'd0;
            end
            mid_q = mid_q + 8'd1;
            if (mid_q == rlmf_pkg::MidWrap) begin
              mid_q  = 8'd0;
              slow_q = slow_q + 8'd1;
              if (slow_q == rlmf_pkg::SlowWrap) begin
                slow_q = 8'd0;
                fire   = 1'b1;
              end
            end
          end
        end
      end
      rlmf_pkg::OpPin: begin
        if (w.button_pressed && !debounce_q)
          mode_q = (mode_q == rlmf_pkg::NumModes - 4'd1) ? rlmf_pkg::ModeOff :
                   mode_q + 4'd1;
        charging_q = w.charger_present;
        if (w.charger_present) budget_q = $signed({1'b0, full_level_q});
        debounce_q = 1'b1;
      end
      rlmf_pkg::OpTimeout: begin
        if (debounce_q) begin
          debounce_q = 1'b0;
          if (w.button_pressed) mode_q = rlmf_pkg::ModeOff;
        end
      end
      default: ;
    endcase

    pins_q = PinsOfMode[mode_q];

    if (mode_q == rlmf_pkg::ModeFastRgb || mode_q == rlmf_pkg::ModeFastRgb2)
      s = int'(fine_q);
    else if (mode_q == rlmf_pkg::ModeSlowRgb || mode_q == rlmf_pkg::ModeSlowRgb2)
      s = int'(coarse_q);
    if (s >= 0) begin
      if (mode_q == rlmf_pkg::ModeSlowRgb || mode_q == rlmf_pkg::ModeFastRgb) begin
        if (s < FadeShortLen) duty_g_q = FadeShort[FadeShortLen - 1 - s];
        else if (s < 2 * FadeShortLen) duty_r_q = FadeShort[s - FadeShortLen];
        else if (s < 3 * FadeShortLen) duty_b_q = FadeShort[3 * FadeShortLen - 1 - s];
        else if (s < 4 * FadeShortLen) duty_g_q = FadeShort[s - 3 * FadeShortLen];
        else if (s < 5 * FadeShortLen) duty_r_q = FadeShort[5 * FadeShortLen - 1 - s];
        else if (s < 6 * FadeShortLen) duty_b_q = FadeShort[s - 5 * FadeShortLen];
      end else begin
        if (s < FadeLongLen) begin
          duty_r_q = FadeLong[s];
          duty_g_q = FadeLong[FadeLongLen - 1 - s];
        end else if (s < 2 * FadeLongLen) begin
          duty_g_q = FadeLong[s - FadeLongLen];
          duty_b_q = FadeLong[2 * FadeLongLen - 1 - s];
        end else if (s < 3 * FadeLongLen) begin
          duty_r_q = FadeLong[3 * FadeLongLen - 1 - s];
          duty_b_q = FadeLong[s - 2 * FadeLongLen];
        end
      end
    end

    // budget underflow forces off and flashes red
    if (mode_q != rlmf_pkg::ModeOff) begin
      if (fire) budget_q = budget_q - $signed({17'd0, CostOfMode[mode_q]});
      if (budget_q[20]) begin
        budget_q = '1;
        mode_q   = rlmf_pkg::ModeOff;
        pins_q   = rlmf_pkg::PinRed;
        flash    = 1'b1;
      end
    end

    pwm = !flash && (mode_q == rlmf_pkg::ModeSlowRgb || mode_q >= rlmf_pkg::ModeFastRgb);
    o.mode_now      = mode_q;
    o.warm_white_on = (pins_q & rlmf_pkg::PinWarm) != 4'b0000;
    o.pwm_active    = pwm;
    if (pwm) begin
      o.red_drive   = duty_r_q != 8'd0;
      o.green_drive = duty_g_q != 8'd0;
      o.blue_drive  = duty_b_q != 8'd0;
    end else begin
      o.red_drive   = (pins_q & rlmf_pkg::PinRed) != 4'b0000;
      o.green_drive = (pins_q & rlmf_pkg::PinGreen) != 4'b0000;
      o.blue_drive  = (pins_q & rlmf_pkg::PinBlue) != 4'b0000;
    end
    o.duty_red         = duty_r_q;
    o.duty_green       = duty_g_q;
    o.duty_blue        = duty_b_q;
    o.charge_led       = charging_q;
    o.low_energy_flash = flash;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    $display("%0t: %s differs, got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic compare_word(input rlmf_pkg::out_word_t g, input rlmf_pkg::out_word_t e);
    if (g.mode_now !== e.mode_now)
      report_mismatch("mode_now", 8'(g.mode_now), 8'(e.mode_now));
    if (g.warm_white_on !== e.warm_white_on)
      report_mismatch("warm_white_on", 8'(g.warm_white_on), 8'(e.warm_white_on));
    if (g.pwm_active !== e.pwm_active)
      report_mismatch("pwm_active", 8'(g.pwm_active), 8'(e.pwm_active));
    if (g.red_drive !== e.red_drive)
      report_mismatch("red_drive", 8'(g.red_drive), 8'(e.red_drive));
    if (g.green_drive !== e.green_drive)
      report_mismatch("green_drive", 8'(g.green_drive), 8'(e.green_drive));
    if (g.blue_drive !== e.blue_drive)
      report_mismatch("blue_drive", 8'(g.blue_drive), 8'(e.blue_drive));
    if (g.duty_red !== e.duty_red)
      report_mismatch("duty_red", g.duty_red, e.duty_red);
    if (g.duty_green !== e.duty_green)
      report_mismatch("duty_green", g.duty_green, e.duty_green);
    if (g.duty_blue !== e.duty_blue)
      report_mismatch("duty_blue", g.duty_blue, e.duty_blue);
    if (g.charge_led !== e.charge_led)
      report_mismatch("charge_led", 8'(g.charge_led), 8'(e.charge_led));
    if (g.low_energy_flash !== e.low_energy_flash)
      report_mismatch("low_energy_flash", 8'(g.low_energy_flash),
                      8'(e.low_energy_flash));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       = rlmf_pkg::ModeOff;
      fine_q       = 8'd0;
      coarse_q     = 8'd0;
      tick_q       = 4'd0;
      mid_q        = 8'd0;
      slow_q       = 8'd0;
      budget_q     = '0;
      debounce_q   = 1'b0;
      charging_q   = 1'b0;
      duty_r_q     = 8'd0;
      duty_g_q     = 8'd0;
      duty_b_q     = 8'd0;
      pins_q       = 4'b0000;
      full_level_q = rlmf_pkg::EnergyFullRst;
      lamp_words_q.delete();
      pending_words_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i == rlmf_pkg::AddrEnergyFull)
        full_level_q = pwdata_i[19:0];
      if (out_valid_i && out_ready_i) begin
        if (lamp_words_q.size() == 0)
          report_mismatch("word with none expected", {4'd0, out_word_i.mode_now}, 8'd0);
        else
          compare_word(out_word_i, lamp_words_q.pop_front());
      end
      if (in_valid_i && in_ready_i) lamp_words_q.push_back(lamp_step(in_word_i));
      pending_words_o <= lamp_words_q.size();
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// testbench top for the rgb lamp mode and fade controller: drives input words,
// result back-pressure and the config port, then prints the verdict
// depends on rlmf_pkg, rgb_lamp_mode_fade_controller and rlmf_lamp_checker
module tb;

  // opcode with no event behind it, only the per-step update runs
  localparam logic [1:0]  OpUnused   = 2'd3;
  localparam logic [19:0] FullMax    = 20'hFFFFF;
  localparam int          PhaseWords = 370;
  // run bound for about 1150 words
  localparam int          CycleLimit = 200_000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  rlmf_pkg::in_word_t  in_word_i   = '0;
  logic                out_ready_i = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [1:0]          paddr       = '0;
  logic [31:0]         pwdata      = '0;
  logic                in_ready_o;
  logic                out_valid_o;
  rlmf_pkg::out_word_t out_word_o;
  logic [31:0]         prdata;
  logic                pready;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stall_len     = 0;
  int          words_sent    = 0;
  int          cycle_count   = 0;
  int          mismatch_count;
  int          pending_words;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rgb_lamp_mode_fade_controller u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  rlmf_lamp_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_word_i        (in_word_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_word_i       (out_word_o),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .pready_i         (pready),
    .mismatch_count_o (mismatch_count),
    .pending_words_o  (pending_words)
  );

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random back-pressure, or one long hold-off when asked for,
  // counted here so the sender keeps offering words and the block fills up
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_len > 0) begin
        out_ready_i <= 1'b0;
        for (int n = 1; n < stall_len; n++) @(posedge clk_i);
        stall_len = 0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offers one word, with random idle cycles ahead of it, and returns at the
  // edge that accepts it; valid stays high so back-to-back words have no gap
  task automatic send_word(input logic [1:0] op, input logic btn, input logic chg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i                <= 1'b1;
    in_word_i.opcode          <= op;
    in_word_i.button_pressed  <= btn;
    in_word_i.charger_present <= chg;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  // drops valid and waits until every predicted word has come back
  task automatic wait_results_in();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
  endtask

  // two-phase write: setup cycle, then the access cycle that lands on pready
  task automatic write_energy_full(input logic [19:0] level);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= rlmf_pkg::AddrEnergyFull;
    pwdata  <= {12'd0, level};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // button and charger levels are don't-care on ticks, so they are randomized
  task automatic send_ticks(input int n);
    repeat (n) send_word(rlmf_pkg::OpTick, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // mostly well-formed press sequences with ticks in between, some noise words
  task automatic random_phase(input int n);
    int stop_at;
    int ticks;
    stop_at = words_sent + n;
    while (words_sent < stop_at) begin
      if ($urandom_range(99) < 80) begin
        send_word(rlmf_pkg::OpPin, $urandom_range(99) < 85, $urandom_range(99) < 20);
        ticks = int'($urandom_range(30));
        send_ticks(ticks);
        // a button still held at the timeout is a long press
        send_word(rlmf_pkg::OpTimeout, $urandom_range(99) < 8, 1'($urandom_range(1)));
      end else begin
        send_word(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words, energy_full still at its reset value
    send_word(rlmf_pkg::OpTick, 1'b1, 1'b1);       // tick while off, timer stopped
    send_word(OpUnused, 1'b1, 1'b1);               // no event
    send_word(rlmf_pkg::OpTimeout, 1'b1, 1'b0);    // timeout while not debouncing
    send_word(rlmf_pkg::OpPin, 1'b1, 1'b1);        // press with charger: warm white
    send_word(rlmf_pkg::OpPin, 1'b1, 1'b0);        // press swallowed while debouncing
    send_word(rlmf_pkg::OpTimeout, 1'b0, 1'b0);
    send_word(rlmf_pkg::OpTick, 1'b0, 1'b0);
    send_word(rlmf_pkg::OpTick, 1'b0, 1'b0);
    send_word(rlmf_pkg::OpPin, 1'b1, 1'b0);        // slow rgb fade
    send_word(rlmf_pkg::OpTimeout, 1'b0, 1'b1);
    send_word(rlmf_pkg::OpTick, 1'b1, 1'b0);
    send_word(rlmf_pkg::OpPin, 1'b1, 1'b0);        // sun
    send_word(rlmf_pkg::OpTimeout, 1'b1, 1'b0);    // long press forces off
    send_word(rlmf_pkg::OpTick, 1'b0, 1'b1);
    send_word(rlmf_pkg::OpPin, 1'b0, 1'b1);        // charger only, no press
    send_word(OpUnused, 1'b0, 1'b0);
    send_word(rlmf_pkg::OpTimeout, 1'b0, 1'b0);
    wait_results_in();

    // sender idles lightly, receiver heavily
    write_energy_full(20'($urandom_range(1, FullMax - 1)));
    send_idle_pct = 36;
    recv_idle_pct = 79;
    random_phase(PhaseWords);
    wait_results_in();

    // the other way round, with one full drain in the middle
    write_energy_full('0);
    send_idle_pct = 79;
    recv_idle_pct = 36;
    random_phase(PhaseWords / 2);
    wait_results_in();
    random_phase(PhaseWords / 2);
    wait_results_in();

    // no idling, starting with a long receiver hold-off
    write_energy_full(FullMax);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_len     = 40;
    random_phase(PhaseWords);
    wait_results_in();

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
